### rtl/whole_word_text_search_core_macros.svh
// Assertion macros for the whole-word text search core.
// No dependencies; included by the top level.
`ifndef WHOLE_WORD_TEXT_SEARCH_CORE_MACROS_SVH
`define WHOLE_WORD_TEXT_SEARCH_CORE_MACROS_SVH

// expr must hold at every clock edge out of reset
`define WWS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// cons must hold in the same cycle as ante
`define WWS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/wws_pkg.sv
// Shared types, constants and byte helpers for the whole-word text search core.
// No dependencies.
package wws_pkg;

    localparam int MAX_PATTERN_DEF  = 16;
    localparam int OFFSET_WIDTH_DEF = 24;
    localparam int LINE_W           = 25;
    localparam int HIT_OFF_W        = 24;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int LEN_REG_W        = 5;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [LINE_W-1:0] LINE_CAP = LINE_W'(1) << 24;

    localparam logic [7:0] ASCII_UNDERSCORE = 8'h5F;
    localparam logic [7:0] ASCII_NEWLINE    = 8'h0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_IGNORE_CASE    = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic                 is_hit;
        logic [LINE_W-1:0]    hit_line;
        logic [LINE_W-1:0]    hit_column;
        logic [HIT_OFF_W-1:0] hit_offset;
        logic                 doc_done;
    } t_out_word;

    // Everything one text byte produces: up to two hits and the done marker
    typedef struct packed {
        logic                 pend_hit;
        logic [LINE_W-1:0]    pend_line;
        logic [LINE_W-1:0]    pend_column;
        logic [HIT_OFF_W-1:0] pend_offset;
        logic                 last_hit;
        logic [LINE_W-1:0]    last_line;
        logic [LINE_W-1:0]    last_column;
        logic [HIT_OFF_W-1:0] last_offset;
        logic                 doc_done;
    } t_job;

    function automatic logic is_word_byte(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || (c == ASCII_UNDERSCORE);
    endfunction

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ign);
        if (ign && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

### rtl/whole_word_text_search_core.sv
// Whole-word text search core: one document byte per cycle in. Every byte
// is taken in the cycle it arrives while the job queue has room; a byte that
// yields results puts one job in a 4-entry queue, and the back end sends one
// result word per cycle unless the output stalls. First words pass through the
// queue and output register; a byte yielding two or three words (hit plus done
// marker) holds the back end until all are sent. The queue absorbs short bursts;
// input stall rises only when it is full. Uses wws_pkg and the macros header.
`include "whole_word_text_search_core_macros.svh"

module whole_word_text_search_core
    import wws_pkg::*;
#(
    parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word
);

    logic                             q_push;
    t_job                             q_job;
    logic                             q_pop;
    logic                             q_head_valid;
    t_job                             q_head;
    logic                             q_full;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    wws_front #(
        .MAX_PATTERN  (MAX_PATTERN),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_job)
    );

    wws_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_job        (q_job),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head),
        .o_full       (q_full),
        .o_count      (q_count)
    );

    wws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word),
        .i_out_stall  (i_out_stall)
    );

    `WWS_ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n, q_count <= QUEUE_DEPTH, "queue count over depth")
    `WWS_ASSERT_IMPLIES(a_hit_xor_done, i_clk, i_rst_n, o_out_valid, o_out_word.is_hit != o_out_word.doc_done, "word is neither hit nor done marker")
    `WWS_ASSERT_IMPLIES(a_done_zero, i_clk, i_rst_n, o_out_valid && o_out_word.doc_done, o_out_word.hit_line == '0 && o_out_word.hit_offset == '0, "done marker carries position")
    `WWS_ASSERT_IMPLIES(a_hit_pos, i_clk, i_rst_n, o_out_valid && o_out_word.is_hit, o_out_word.hit_line != '0 && o_out_word.hit_column != '0, "hit with zero line or column")

endmodule

### rtl/wws_front.sv
// Front end: config registers, text window, position counters and match test.
// Turns each accepted byte that yields a result into one queue job. Depends on wws_pkg.
module wws_front
    import wws_pkg::*;
#(
    parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  t_in_word              i_in_word,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_job                  o_job
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W = OFFSET_WIDTH + 1;

    logic [63:0]          r_pat_low;
    logic [63:0]          r_pat_high;
    logic [LEN_REG_W-1:0] r_pat_len;
    logic                 r_ign;

    logic [7:0]        r_wb [MAX_PATTERN];
    logic [LINE_W-1:0] r_wl [MAX_PATTERN];
    logic [LINE_W-1:0] r_wc [MAX_PATTERN];

    logic [CNT_W-1:0]     r_bcount, n_bcount;
    logic [CNT_W-1:0]     r_resume, n_resume;
    logic [LINE_W-1:0]    r_line, n_line;
    logic [LINE_W-1:0]    r_col, n_col;
    logic                 r_pend_valid, n_pend_valid;
    logic                 r_pend_front, n_pend_front;
    logic [LINE_W-1:0]    r_pend_line;
    logic [LINE_W-1:0]    r_pend_col;
    logic [HIT_OFF_W-1:0] r_pend_off;

    logic                 accept;
    logic [7:0]           c;
    logic                 last;
    logic [127:0]         pat_vec;
    logic [LEN_W-1:0]     len_eff;
    logic [7:0]           w  [MAX_PATTERN+1];
    logic [LINE_W-1:0]    wl [MAX_PATTERN];
    logic [LINE_W-1:0]    wc [MAX_PATTERN];
    logic                 all_eq;
    logic [7:0]           front_byte;
    logic [LINE_W-1:0]    start_line;
    logic [LINE_W-1:0]    start_col;
    logic [CNT_W-1:0]     off_p1;
    logic [CNT_W-1:0]     len_ext;
    logic [CNT_W-1:0]     start;
    logic                 in_range;
    logic                 match_ok;
    logic                 front_ok;
    logic                 pend_fire;
    logic                 last_fire;

    assign accept  = i_in_valid && !i_q_full;
    assign c       = i_in_word.text_byte;
    assign last    = i_in_word.last_byte;
    assign pat_vec = {r_pat_high, r_pat_low};

    always_comb begin
        if (r_pat_len > LEN_REG_W'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end else begin
            len_eff = LEN_W'(r_pat_len);
        end
    end

    // window as it stands once this byte is shifted in
    always_comb begin
        logic [3:0] pidx;
        pidx       = '0;
        all_eq     = 1'b1;
        front_byte = '0;
        start_line = '0;
        start_col  = '0;
        w[0]  = c;
        wl[0] = r_line;
        wc[0] = r_col;
        for (int k = 1; k <= MAX_PATTERN; k++) begin
            w[k] = r_wb[k-1];
        end
        for (int k = 1; k < MAX_PATTERN; k++) begin
            wl[k] = r_wl[k-1];
            wc[k] = r_wc[k-1];
        end
        // window position j lines up with pattern byte len-1-j
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (j < int'(len_eff)) begin
                pidx = 4'(int'(len_eff) - 1 - j);
                if (fold_byte(w[j], r_ign) != fold_byte(pat_vec[pidx*8 +: 8], r_ign)) begin
                    all_eq = 1'b0;
                end
            end
        end
        for (int k = 0; k <= MAX_PATTERN; k++) begin
            if (k == int'(len_eff)) begin
                front_byte = w[k];
            end
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k == int'(len_eff) - 1) begin
                start_line = wl[k];
                start_col  = wc[k];
            end
        end
    end

    assign in_range = !r_bcount[OFFSET_WIDTH];
    assign off_p1   = r_bcount + CNT_W'(1);
    assign len_ext  = CNT_W'(len_eff);
    assign start    = off_p1 - len_ext;
    assign match_ok = (len_eff != '0) && in_range && (off_p1 >= len_ext) &&
                      (start >= r_resume) && all_eq;
    assign front_ok = (start == '0) || !is_word_byte(front_byte);

    assign pend_fire = r_pend_valid && r_pend_front && !is_word_byte(c);
    assign last_fire = match_ok && last && front_ok;

    always_comb begin
        o_job.pend_hit    = pend_fire;
        o_job.pend_line   = r_pend_line;
        o_job.pend_column = r_pend_col;
        o_job.pend_offset = r_pend_off;
        o_job.last_hit    = last_fire;
        o_job.last_line   = start_line;
        o_job.last_column = start_col;
        o_job.last_offset = HIT_OFF_W'(start);
        o_job.doc_done    = last;
    end

    assign o_push = accept && (pend_fire || last_fire || last);

    always_comb begin
        n_bcount     = r_bcount;
        n_resume     = r_resume;
        n_line       = r_line;
        n_col        = r_col;
        n_pend_valid = r_pend_valid;
        n_pend_front = r_pend_front;
        if (accept) begin
            if (last) begin
                n_bcount     = '0;
                n_resume     = '0;
                n_line       = LINE_W'(1);
                n_col        = LINE_W'(1);
                n_pend_valid = 1'b0;
                n_pend_front = 1'b0;
            end else begin
                if (in_range) begin
                    n_bcount = off_p1;
                end
                if (match_ok) begin
                    n_resume = off_p1;
                end
                if (c == ASCII_NEWLINE) begin
                    if (r_line < LINE_CAP) begin
                        n_line = r_line + LINE_W'(1);
                    end
                    n_col = LINE_W'(1);
                end else if (r_col < LINE_CAP) begin
                    n_col = r_col + LINE_W'(1);
                end
                n_pend_valid = match_ok;
                n_pend_front = match_ok && front_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low    <= '0;
            r_pat_high   <= '0;
            r_pat_len    <= LEN_REG_W'(1);
            r_ign        <= 1'b0;
            r_bcount     <= '0;
            r_resume     <= '0;
            r_line       <= LINE_W'(1);
            r_col        <= LINE_W'(1);
            r_pend_valid <= 1'b0;
            r_pend_front <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                    CFG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                    CFG_PATTERN_LENGTH: r_pat_len  <= i_cfg_data[LEN_REG_W-1:0];
                    CFG_IGNORE_CASE:    r_ign      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_bcount     <= n_bcount;
            r_resume     <= n_resume;
            r_line       <= n_line;
            r_col        <= n_col;
            r_pend_valid <= n_pend_valid;
            r_pend_front <= n_pend_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_wb[k] <= w[k];
                r_wl[k] <= wl[k];
                r_wc[k] <= wc[k];
            end
            if (match_ok && !last) begin
                r_pend_line <= start_line;
                r_pend_col  <= start_col;
                r_pend_off  <= HIT_OFF_W'(start);
            end
        end
    end

endmodule

### rtl/wws_queue.sv
// Short job queue between front and back ends, register based.
// Depends on wws_pkg.
module wws_queue
    import wws_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  t_job                              i_job,
    input  logic                              i_pop,
    output logic                              o_head_valid,
    output t_job                              o_head,
    output logic                              o_full,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  o_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_count      = r_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### rtl/wws_back.sv
// Back end: unpacks each queued job into result words, one per cycle while the
// output is not stalled, through the output register. Depends on wws_pkg.
module wws_back
    import wws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_job      i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    logic [2:0] r_sent, n_sent;
    logic       r_out_valid, n_out_valid;
    t_out_word  r_out_word;

    logic [2:0] parts;
    logic [2:0] remain;
    logic [2:0] sel;
    logic       load;
    t_out_word  pick;

    // bit 0 pending hit, bit 1 hit on the final byte, bit 2 done marker
    assign parts  = {i_head.doc_done, i_head.last_hit, i_head.pend_hit};
    assign remain = parts & ~r_sent;
    assign load   = i_head_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        pick = '0;
        priority if (remain[0]) begin
            sel             = 3'b001;
            pick.is_hit     = 1'b1;
            pick.hit_line   = i_head.pend_line;
            pick.hit_column = i_head.pend_column;
            pick.hit_offset = i_head.pend_offset;
        end else if (remain[1]) begin
            sel             = 3'b010;
            pick.is_hit     = 1'b1;
            pick.hit_line   = i_head.last_line;
            pick.hit_column = i_head.last_column;
            pick.hit_offset = i_head.last_offset;
        end else begin
            sel           = 3'b100;
            pick.doc_done = 1'b1;
        end
    end

    assign o_pop = load && ((remain & ~sel) == 3'b000);

    always_comb begin
        n_sent      = r_sent;
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
            n_sent      = o_pop ? 3'b000 : (r_sent | sel);
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sent      <= n_sent;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_word <= pick;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
